>>> src/bmas_pkg.sv
package bmas_pkg;

	// Defaults for the sizing parameters
	localparam int MAX_ROWS_DEF    = 256;
	localparam int MAX_TARGETS_DEF = 16;

	// Field widths
	localparam int ACT_W   = 2;
	localparam int ROW_W   = 8;
	localparam int COL_W   = 4;
	localparam int VAL_W   = 32;
	localparam int SUM_W   = 64;
	localparam int RC_W    = 9;
	localparam int TC_W    = 5;
	localparam int INV_W   = 17;
	localparam int CFG_W   = 17;
	localparam int CIDX_W  = 2;
	localparam int RWIDE_W = 13;
	localparam int TWIDE_W = 7;
	localparam int IN_DATA_W  = 48;
	localparam int OUT_DATA_W = 32;

	// Action codes
	localparam logic [ACT_W-1:0] ACT_SCORE  = 2'd0;
	localparam logic [ACT_W-1:0] ACT_SCALE  = 2'd1;
	localparam logic [ACT_W-1:0] ACT_WEIGHT = 2'd2;

	// Register indexes
	localparam logic [CIDX_W-1:0] REG_ROWS    = 2'd0;
	localparam logic [CIDX_W-1:0] REG_TARGETS = 2'd1;
	localparam logic [CIDX_W-1:0] REG_INV     = 2'd2;

	localparam logic [INV_W-1:0] INV_MAX = 17'd65536;

	// Word travelling down the cell chain
	typedef struct packed {
		logic                    vld;
		logic [ACT_W-1:0]        act;
		logic [ROW_W-1:0]        row;
		logic [COL_W-1:0]        col;
		logic signed [VAL_W-1:0] value;
	} item_t;

	// Per-target entry shifted out at the end of a draw
	typedef struct packed {
		logic                    used;
		logic signed [SUM_W-1:0] sum;
		logic signed [VAL_W-1:0] se;
	} unload_t;

endpackage

>>> src/bmas_ram.sv
module bmas_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

>>> src/bmas_cell.sv
module bmas_cell #(
	parameter int MAX_ROWS = 256,
	parameter int IDX      = 0
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  bmas_pkg::item_t  item_in,
	output bmas_pkg::item_t  item_out,
	input  logic             cap,
	input  logic             shift,
	input  bmas_pkg::unload_t ul_in,
	output bmas_pkg::unload_t ul_out
);
	import bmas_pkg::*;

	localparam int AW = $clog2(MAX_ROWS);

	item_t                   itm_s1;
	logic                    vld_s2;
	logic signed [VAL_W-1:0] wgt_s2;
	logic                    vld_s3;
	logic signed [SUM_W-1:0] prod_s3;
	logic signed [SUM_W-1:0] sum_q;
	logic signed [VAL_W-1:0] se_q;
	unload_t                 ul_q;
	logic [VAL_W-1:0]        rdata;
	logic                    sc_we;
	logic                    mine;
	logic [AW-1:0]           addr;
	logic signed [SUM_W:0]   sum_x;
	logic signed [SUM_W-1:0] sum_n;

	assign mine  = (32'(itm_s1.col) == 32'(IDX));
	assign addr  = AW'(itm_s1.row);
	assign sc_we = itm_s1.vld && itm_s1.act == ACT_SCORE && mine
		&& (32'(itm_s1.row) < 32'(MAX_ROWS));

	bmas_ram #(.WIDTH(VAL_W), .DEPTH(MAX_ROWS)) u_ram (
		.clk   (clk),
		.we    (sc_we),
		.waddr (addr),
		.wdata (itm_s1.value),
		.raddr (addr),
		.rdata (rdata)
	);

	// saturating accumulate
	always_comb begin
		sum_x = {sum_q[SUM_W-1], sum_q} + {prod_s3[SUM_W-1], prod_s3};
		if (sum_x[SUM_W] != sum_x[SUM_W-1]) begin
			sum_n = sum_x[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
		end else begin
			sum_n = sum_x[SUM_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			itm_s1 <= '0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			sum_q  <= '0;
		end else begin
			itm_s1 <= item_in;
			vld_s2 <= itm_s1.vld && itm_s1.act == ACT_WEIGHT && en;
			vld_s3 <= vld_s2;
			if (cap) begin
				sum_q <= '0;
			end else if (vld_s3) begin
				sum_q <= sum_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		wgt_s2  <= itm_s1.value;
		prod_s3 <= wgt_s2 * $signed(rdata);
		if (itm_s1.vld && itm_s1.act == ACT_SCALE && mine) begin
			se_q <= itm_s1.value;
		end
		if (cap) begin
			ul_q <= '{used: en, sum: sum_q, se: se_q};
		end else if (shift) begin
			ul_q <= ul_in;
		end
	end

	assign item_out = itm_s1;
	assign ul_out   = ul_q;

endmodule

>>> src/bmas_scale.sv
module bmas_scale (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          clr,
	input  logic [bmas_pkg::INV_W-1:0]    inv,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  bmas_pkg::unload_t             entry,
	output logic                          busy,
	output logic [bmas_pkg::VAL_W-1:0]    best,
	output logic                          bad
);
	import bmas_pkg::*;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_MUL  = 3'd1;
	localparam logic [2:0] S_CHK  = 3'd2;
	localparam logic [2:0] S_DIV  = 3'd3;
	localparam logic [2:0] S_UPD  = 3'd4;

	logic [2:0]        st_q;
	logic [47:0]       a_q;
	logic [30:0]       se_q;
	logic [63:0]       b_q;
	logic [30:0]       rem_q;
	logic [31:0]       quo_q;
	logic [4:0]        cnt_q;
	logic [31:0]       best_q;
	logic              bad_q;
	logic [SUM_W-1:0]  mag;
	logic [31:0]       rem2;
	logic              ge;
	logic [31:0]       diff;

	assign mag  = entry.sum[SUM_W-1] ? (~entry.sum) + 64'd1 : entry.sum;
	assign rem2 = {rem_q, quo_q[31]};
	assign ge   = rem2 >= {1'b0, se_q};
	assign diff = rem2 - {1'b0, se_q};

	assign in_ready = (st_q == S_IDLE);
	assign busy     = (st_q != S_IDLE);
	assign best     = best_q;
	assign bad      = bad_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= S_IDLE;
			best_q <= '0;
			bad_q  <= 1'b0;
			cnt_q  <= '0;
		end else begin
			case (st_q)
				S_IDLE: begin
					if (clr) begin
						best_q <= '0;
						bad_q  <= 1'b0;
					end else if (in_valid && entry.used) begin
						if (entry.se[VAL_W-1] || entry.se == '0) begin
							bad_q <= 1'b1;
						end else begin
							st_q <= S_MUL;
						end
					end
				end
				S_MUL: st_q <= S_CHK;
				S_CHK: begin
					if (b_q[63:32] >= {1'b0, se_q}) begin
						best_q <= 32'hFFFF_FFFF;
						st_q   <= S_IDLE;
					end else begin
						cnt_q <= '0;
						st_q  <= S_DIV;
					end
				end
				S_DIV: begin
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'd31) begin
						st_q <= S_UPD;
					end
				end
				S_UPD: begin
					if (quo_q > best_q) begin
						best_q <= quo_q;
					end
					st_q <= S_IDLE;
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (st_q == S_IDLE) begin
			a_q  <= mag[63:16];
			se_q <= entry.se[30:0];
		end
		if (st_q == S_MUL) begin
			b_q <= 64'(a_q) * 64'(inv);
		end
		if (st_q == S_CHK) begin
			rem_q <= b_q[62:32];
			quo_q <= b_q[31:0];
		end
		if (st_q == S_DIV) begin
			// one quotient bit per cycle
			rem_q <= ge ? diff[30:0] : rem2[30:0];
			quo_q <= {quo_q[30:0], ge};
		end
	end

endmodule

>>> src/bootstrap_max_abs_statistic.sv
// A weight, score or scale word enters the cell row through a register, and one word is
// taken per cycle while a draw is open. The last weight of a draw closes input through
// drain and capture, then each target passes through the shared scale unit (with its
// one-bit-per-cycle divider), then through the output stage before the result shows;
// a result still held there stalls the next draw. Reset (arst_n low) clears control and
// accumulators and loads the configuration defaults; score and scale stores hold nothing
// defined until loaded.
module bootstrap_max_abs_statistic #(
	parameter int MAX_ROWS    = bmas_pkg::MAX_ROWS_DEF,
	parameter int MAX_TARGETS = bmas_pkg::MAX_TARGETS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// row [7:0], column [11:8], value [43:12], zero [47:44]
	input  logic [bmas_pkg::IN_DATA_W-1:0]      s_tdata,
	// action [1:0]
	input  logic [bmas_pkg::ACT_W-1:0]          s_tuser,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// draw_max [31:0]
	output logic [bmas_pkg::OUT_DATA_W-1:0]     m_tdata,
	// bad_scale [0]
	output logic                                m_tuser,
	input  logic                                cfg_we,
	input  logic [bmas_pkg::CIDX_W-1:0]         cfg_idx,
	input  logic [bmas_pkg::CFG_W-1:0]          cfg_data
);
	import bmas_pkg::*;

	localparam int CW = $clog2(MAX_TARGETS + 6);

	// Control states
	localparam logic [2:0] ST_RUN    = 3'd0;
	localparam logic [2:0] ST_DRAIN  = 3'd1;
	localparam logic [2:0] ST_CAP    = 3'd2;
	localparam logic [2:0] ST_UNLOAD = 3'd3;
	localparam logic [2:0] ST_OUT    = 3'd4;

	logic [2:0]         st_q;
	logic [CW-1:0]      cnt_q;
	logic [RC_W-1:0]    rows_q;
	logic [TC_W-1:0]    tgts_q;
	logic [INV_W-1:0]   inv_q;
	logic               out_vld_q;
	logic [31:0]        dmax_q;
	logic               bad_q;

	logic [RWIDE_W-1:0] eff_rows;
	logic [TWIDE_W-1:0] eff_tgts;
	logic [INV_W-1:0]   eff_inv;
	logic               acc;
	logic               row_ok;
	logic               last_w;
	item_t              entry;
	item_t              chain [MAX_TARGETS+1];
	unload_t            ul    [MAX_TARGETS+1];
	logic               cap;
	logic               shift;
	logic               sc_valid;
	logic               sc_ready;
	logic               sc_busy;
	logic [31:0]        sc_best;
	logic               sc_bad;

	// Clamp the registers to their working ranges
	always_comb begin
		if (rows_q == '0) begin
			eff_rows = RWIDE_W'(1);
		end else if (RWIDE_W'(rows_q) > RWIDE_W'(MAX_ROWS)) begin
			eff_rows = RWIDE_W'(MAX_ROWS);
		end else begin
			eff_rows = RWIDE_W'(rows_q);
		end
		if (tgts_q == '0) begin
			eff_tgts = TWIDE_W'(1);
		end else if (TWIDE_W'(tgts_q) > TWIDE_W'(MAX_TARGETS)) begin
			eff_tgts = TWIDE_W'(MAX_TARGETS);
		end else begin
			eff_tgts = TWIDE_W'(tgts_q);
		end
		eff_inv = (inv_q > INV_MAX) ? INV_MAX : inv_q;
	end

	assign s_tready = (st_q == ST_RUN);
	assign acc      = s_tvalid && s_tready;
	assign row_ok   = RWIDE_W'(s_tdata[7:0]) < eff_rows;
	assign last_w   = RWIDE_W'(s_tdata[7:0]) == (eff_rows - RWIDE_W'(1));

	// Drop weights beyond the draw and unused actions at the chain entry
	always_comb begin
		entry.act   = s_tuser;
		entry.row   = s_tdata[7:0];
		entry.col   = s_tdata[11:8];
		entry.value = s_tdata[43:12];
		entry.vld   = acc && (s_tuser == ACT_SCORE || s_tuser == ACT_SCALE
			|| (s_tuser == ACT_WEIGHT && row_ok));
	end

	assign chain[0] = entry;
	assign ul[0]    = '0;
	assign cap      = (st_q == ST_CAP);
	assign sc_valid = (st_q == ST_UNLOAD) && (cnt_q != '0);
	assign shift    = sc_valid && sc_ready;

	// One cell per target; words walk down the row one cell per cycle, and at the
	// end of a draw the captured sums shift toward the tail into the scale unit.
	for (genvar k = 0; k < MAX_TARGETS; k++) begin : g_cell
		bmas_cell #(.MAX_ROWS(MAX_ROWS), .IDX(k)) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (TWIDE_W'(k) < eff_tgts),
			.item_in  (chain[k]),
			.item_out (chain[k+1]),
			.cap      (cap),
			.shift    (shift),
			.ul_in    (ul[k]),
			.ul_out   (ul[k+1])
		);
	end

	bmas_scale u_scale (
		.clk      (clk),
		.arst_n   (arst_n),
		.clr      (cap),
		.inv      (eff_inv),
		.in_valid (sc_valid),
		.in_ready (sc_ready),
		.entry    (ul[MAX_TARGETS]),
		.busy     (sc_busy),
		.best     (sc_best),
		.bad      (sc_bad)
	);

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q <= RC_W'(256);
			tgts_q <= TC_W'(16);
			inv_q  <= INV_W'(4096);
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_ROWS:    rows_q <= cfg_data[RC_W-1:0];
				REG_TARGETS: tgts_q <= cfg_data[TC_W-1:0];
				REG_INV:     inv_q  <= cfg_data[INV_W-1:0];
				default:     ;
			endcase
		end
	end

	// Draw sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q      <= ST_RUN;
			cnt_q     <= '0;
			out_vld_q <= 1'b0;
		end else begin
			// load a new result once the slot is free, else drop a taken one
			if (st_q == ST_OUT && (!out_vld_q || m_tready)) begin
				out_vld_q <= 1'b1;
			end else if (m_tvalid && m_tready) begin
				out_vld_q <= 1'b0;
			end
			case (st_q)
				ST_RUN: begin
					// advance to drain once the closing weight is in the row
					if (entry.vld && entry.act == ACT_WEIGHT && last_w) begin
						cnt_q <= CW'(MAX_TARGETS + 4);
						st_q  <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (cnt_q == '0) begin
						st_q <= ST_CAP;
					end else begin
						cnt_q <= cnt_q - CW'(1);
					end
				end
				ST_CAP: begin
					cnt_q <= CW'(MAX_TARGETS);
					st_q  <= ST_UNLOAD;
				end
				ST_UNLOAD: begin
					if (shift) begin
						cnt_q <= cnt_q - CW'(1);
					end
					if (cnt_q == '0 && !sc_busy) begin
						st_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					// hold until the previous result has been taken
					if (!out_vld_q || m_tready) begin
						st_q <= ST_RUN;
					end
				end
				default: st_q <= ST_RUN;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (st_q == ST_OUT && (!out_vld_q || m_tready)) begin
			dmax_q <= sc_bad ? 32'd0 : sc_best;
			bad_q  <= sc_bad;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = dmax_q;
	assign m_tuser  = bad_q;

endmodule

>>> dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
	import bmas_pkg::*;

	localparam int N_ROWS      = MAX_ROWS_DEF;
	localparam int N_TARGETS   = MAX_TARGETS_DEF;
	// action code that the block ignores
	localparam logic [ACT_W-1:0] ACT_SPARE = 2'd3;
	// quiet cycles before a register write: drain plus a full scale pass
	localparam int QUIET_CYCLES = N_TARGETS * 40 + 60;
	localparam int CALM_TAIL    = 80;
	localparam int LIMIT_CYCLES = 1_000_000;

	typedef enum logic [1:0] {OP_WORD, OP_CFG, OP_DRAIN} op_kind_t;

	typedef struct {
		op_kind_t          kind;
		logic [ACT_W-1:0]  act;
		logic [ROW_W-1:0]  row;
		logic [COL_W-1:0]  col;
		logic [VAL_W-1:0]  value;
		logic [CIDX_W-1:0] idx;
		logic [CFG_W-1:0]  data;
	} op_t;

	typedef struct {
		logic [OUT_DATA_W-1:0] draw_max;
		logic                  bad_scale;
	} draw_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [IN_DATA_W-1:0] s_tdata = '0;
	logic [ACT_W-1:0] s_tuser = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic m_tuser;
	logic cfg_we = 1'b0;
	logic [CIDX_W-1:0] cfg_idx = '0;
	logic [CFG_W-1:0] cfg_data = '0;

	op_t          pending_ops[$];
	draw_result_t draws_due[$];
	int           errors = 0;
	int           words_taken = 0;
	int           cycle_count = 0;

	// predictor state
	logic [RC_W-1:0]  pr_rows = RC_W'(256);
	logic [TC_W-1:0]  pr_targets = TC_W'(16);
	logic [INV_W-1:0] pr_inv = INV_W'(4096);
	int               pr_score[N_ROWS*N_TARGETS];
	int               pr_scale[N_TARGETS];
	longint           pr_sum[N_TARGETS];

	// generator bookkeeping: which score entries were loaded
	bit score_loaded[N_ROWS*N_TARGETS];
	int gen_rows = 256;
	int gen_targets = 16;
	int words_made = 0;

	always #2 clk = ~clk;

	bootstrap_max_abs_statistic i_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
	);

	function automatic int eff_rows(int r);
		if (r == 0) return 1;
		return r > N_ROWS ? N_ROWS : r;
	endfunction

	function automatic int eff_targets(int t);
		if (t == 0) return 1;
		return t > N_TARGETS ? N_TARGETS : t;
	endfunction

	// Fold one accepted word into the predictor; queue a draw result on the last row.
	function automatic void accumulate_word(logic [ACT_W-1:0] act, logic [ROW_W-1:0] row,
			logic [COL_W-1:0] col, logic [VAL_W-1:0] value);
		int nr;
		int nt;
		longint prod;
		longint s;
		longint unsigned mag;
		longint unsigned q;
		longint unsigned best;
		logic bad;
		draw_result_t res;
		nr = eff_rows(pr_rows);
		nt = eff_targets(pr_targets);
		best = 0;
		bad = 1'b0;
		case (act)
			ACT_SCORE: pr_score[row*N_TARGETS + col] = value;
			ACT_SCALE: pr_scale[col] = value;
			ACT_WEIGHT: begin
				if (row >= nr)
					return;
				for (int t = 0; t < nt; t++) begin
					prod = longint'($signed(value)) * longint'(pr_score[row*N_TARGETS + t]);
					s = pr_sum[t] + prod;
					// saturate on signed overflow
					if (pr_sum[t][63] == prod[63] && s[63] != prod[63])
						s = prod[63] ? 64'sh8000_0000_0000_0000 : 64'sh7FFF_FFFF_FFFF_FFFF;
					pr_sum[t] = s;
				end
				if (row != nr - 1)
					return;
				for (int t = 0; t < nt; t++) begin
					if (pr_scale[t] <= 0) begin
						bad = 1'b1;
					end else begin
						mag = pr_sum[t] < 0 ? ~pr_sum[t] + 64'd1 : pr_sum[t];
						mag = mag >> 16;
						q = (mag * longint'(pr_inv > INV_MAX ? INV_MAX : pr_inv))
							/ longint'(pr_scale[t]);
						if (q > 64'hFFFF_FFFF)
							q = 64'hFFFF_FFFF;
						if (q > best)
							best = q;
					end
				end
				for (int t = 0; t < N_TARGETS; t++)
					pr_sum[t] = 0;
				res.draw_max = bad ? '0 : best[31:0];
				res.bad_scale = bad;
				draws_due.push_back(res);
			end
			default: ;
		endcase
	endfunction

	// ---------------------------------------------------------------- stimulus
	task automatic push_word(logic [ACT_W-1:0] act, int row, int col, logic [31:0] value);
		op_t op;
		op.kind = OP_WORD;
		op.act = act;
		op.row = ROW_W'(row);
		op.col = COL_W'(col);
		op.value = value;
		op.idx = '0;
		op.data = '0;
		pending_ops.push_back(op);
		words_made++;
		if (act == ACT_SCORE)
			score_loaded[row*N_TARGETS + col] = 1'b1;
	endtask

	task automatic push_ctl(op_kind_t kind, logic [CIDX_W-1:0] idx, int data);
		op_t op;
		op.kind = kind;
		op.act = ACT_SPARE;
		op.row = '0;
		op.col = '0;
		op.value = '0;
		op.idx = idx;
		op.data = CFG_W'(data);
		pending_ops.push_back(op);
		if (kind == OP_CFG && idx == REG_ROWS)
			gen_rows = eff_rows(data & 32'h1FF);
		if (kind == OP_CFG && idx == REG_TARGETS)
			gen_targets = eff_targets(data & 32'h1F);
	endtask

	function automatic logic [31:0] rand_value();
		case ($urandom_range(0, 5))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2, 3: return $urandom();
			default: return 32'($signed($urandom_range(0, 262143)) - 131072);
		endcase
	endfunction

	function automatic logic [31:0] rand_scale();
		case ($urandom_range(0, 11))
			0: return 32'h0;
			1: return 32'h8000_0000 | $urandom();
			2: return 32'h7FFF_FFFF;
			3: return 32'd1;
			4, 5: return $urandom() & 32'h7FFF_FFFF;
			default: return $urandom_range(4096, 262144);
		endcase
	endfunction

	task automatic load_row(int r);
		for (int t = 0; t < gen_targets; t++)
			if (!score_loaded[r*N_TARGETS + t])
				push_word(ACT_SCORE, r, t, rand_value());
	endtask

	// ignored words and harmless reloads scattered through a draw
	task automatic push_noise();
		case ($urandom_range(0, 3))
			0: push_word(ACT_SPARE, $urandom_range(0, 255), $urandom_range(0, 15), $urandom());
			1: if (gen_rows < N_ROWS)
				push_word(ACT_WEIGHT, $urandom_range(gen_rows, 255), $urandom_range(0, 15),
					$urandom());
			2: push_word(ACT_SCORE, $urandom_range(0, 255), $urandom_range(0, 15), rand_value());
			default: push_word(ACT_SCALE, 0, $urandom_range(0, 15), rand_scale());
		endcase
	endtask

	task automatic push_draw();
		int extra;
		int r;
		extra = gen_rows > 1 ? $urandom_range(0, gen_rows - 1 < 5 ? gen_rows - 1 : 5) : 0;
		repeat (extra) begin
			r = $urandom_range(0, gen_rows - 2);
			load_row(r);
			if ($urandom_range(0, 5) == 0)
				push_noise();
			push_word(ACT_WEIGHT, r, $urandom_range(0, 15),
				$urandom_range(0, 1) ? rand_value() : $urandom_range(0, 131072));
		end
		load_row(gen_rows - 1);
		push_word(ACT_WEIGHT, gen_rows - 1, $urandom_range(0, 15), rand_value());
	endtask

	task automatic push_settings(int rows, int targets, int inv);
		push_ctl(OP_CFG, REG_ROWS, rows);
		push_ctl(OP_CFG, REG_TARGETS, targets);
		push_ctl(OP_CFG, REG_INV, inv);
	endtask

	// ---------------------------------------------------------------- driver
	always @(posedge clk or negedge arst_n) begin : driver
		op_t op;
		logic nv;
		logic nwe;
		int quiet;
		int gap;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			cfg_we <= 1'b0;
			quiet = 0;
			gap = 0;
		end else begin
			nv = s_tvalid;
			nwe = 1'b0;
			quiet = (s_tvalid || m_tvalid) ? 0 : quiet + 1;
			if (s_tvalid && s_tready) begin
				accumulate_word(s_tuser, s_tdata[7:0], s_tdata[11:8], s_tdata[43:12]);
				words_taken++;
				nv = 1'b0;
			end
			// hold a word that has not been taken yet
			if (!nv) begin
				if (gap > 0) begin
					gap--;
				end else if (pending_ops.size() > 0) begin
					op = pending_ops[0];
					case (op.kind)
						OP_WORD: begin
							if (pending_ops.size() > CALM_TAIL && $urandom_range(0, 9) == 0) begin
								gap = $urandom_range(0, 11);
							end else begin
								void'(pending_ops.pop_front());
								nv = 1'b1;
								s_tuser <= op.act;
								s_tdata <= {4'b0, op.value, op.col, op.row};
							end
						end
						OP_CFG: begin
							// write only when idle: nothing due and the block has gone quiet
							if (draws_due.size() == 0 && quiet >= QUIET_CYCLES) begin
								void'(pending_ops.pop_front());
								nwe = 1'b1;
								cfg_idx <= op.idx;
								cfg_data <= op.data;
								case (op.idx)
									REG_ROWS: pr_rows = op.data[RC_W-1:0];
									REG_TARGETS: pr_targets = op.data[TC_W-1:0];
									default: pr_inv = op.data[INV_W-1:0];
								endcase
							end
						end
						default: begin
							// pause until every pending draw result has come back
							if (draws_due.size() == 0)
								void'(pending_ops.pop_front());
						end
					endcase
				end
			end
			s_tvalid <= nv;
			cfg_we <= nwe;
		end
	end

	// ---------------------------------------------------------------- monitor
	always @(posedge clk or negedge arst_n) begin : monitor
		draw_result_t want;
		int stall;
		bit long_done;
		if (!arst_n) begin
			m_tready <= 1'b0;
			stall = 0;
			long_done = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (draws_due.size() == 0) begin
					$error("unexpected draw result: draw_max=%h bad_scale=%b", m_tdata, m_tuser);
					errors++;
				end else begin
					want = draws_due.pop_front();
					if (m_tdata !== want.draw_max) begin
						$error("draw_max: expected %h, got %h", want.draw_max, m_tdata);
						errors++;
					end
					if (m_tuser !== want.bad_scale) begin
						$error("bad_scale: expected %b, got %b", want.bad_scale, m_tuser);
						errors++;
					end
				end
			end
			// one long hold-off midway so the block backs up into its input
			if (!long_done && words_taken >= 250) begin
				long_done = 1;
				stall = 400;
			end
			if (stall > 0) begin
				stall--;
				m_tready <= 1'b0;
			end else if (pending_ops.size() > CALM_TAIL && $urandom_range(0, 7) == 0) begin
				stall = $urandom_range(0, 11);
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// ---------------------------------------------------------------- watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= LIMIT_CYCLES) begin
			$display("FAIL bootstrap_max_abs_statistic");
			$finish;
		end
	end

	// ---------------------------------------------------------------- sequence
	initial begin : sequencer
		int rows_x[6];
		int targets_x[6];
		int inv_x[6];
		rows_x    = '{1, 256, 0, 511, 4, 2};
		targets_x = '{1, 16, 0, 31, 16, 7};
		inv_x     = '{65536, 0, 131071, 1, 4096, 65535};
		foreach (pr_sum[t])
			pr_sum[t] = 0;

		// directed: reset settings, extreme scales and scores on the last row
		for (int t = 0; t < N_TARGETS; t++)
			push_word(ACT_SCALE, 0, t, t == 0 ? 32'd1 : t == 1 ? 32'h7FFF_FFFF :
				$urandom_range(1, 32'h7FFF_FFFF));
		for (int t = 0; t < N_TARGETS; t++)
			push_word(ACT_SCORE, 255, t, t == 0 ? 32'h7FFF_FFFF : t == 1 ? 32'h8000_0000 :
				rand_value());
		push_word(ACT_SPARE, 255, 15, 32'hFFFF_FFFF);
		push_word(ACT_WEIGHT, 255, 0, 32'h7FFF_FFFF);
		push_word(ACT_WEIGHT, 255, 0, 32'h8000_0000);
		push_word(ACT_SCALE, 0, 2, 32'h0);
		push_word(ACT_WEIGHT, 255, 0, 32'h0001_0000);
		push_word(ACT_SCALE, 0, 2, 32'h0001_0000);
		push_ctl(OP_DRAIN, '0, 0);

		// extreme settings first, then random ones
		for (int p = 0; words_made < 600 || p < 6; p++) begin
			if (p < 6)
				push_settings(rows_x[p], targets_x[p], inv_x[p]);
			else
				push_settings($urandom_range(0, 3) == 0 ? $urandom_range(0, 511) :
					$urandom_range(1, 8), $urandom_range(0, 31), $urandom_range(0, 131071));
			repeat ($urandom_range(2, 6)) begin
				push_draw();
				if ($urandom_range(0, 9) == 0)
					push_ctl(OP_DRAIN, '0, 0);
			end
		end

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		wait (pending_ops.size() == 0 && !s_tvalid && draws_due.size() == 0);
		repeat (QUIET_CYCLES) @(posedge clk);
		if (draws_due.size() != 0) begin
			$error("%0d draw results never came", draws_due.size());
			errors++;
		end
		if (errors == 0)
			$display("PASS bootstrap_max_abs_statistic");
		else
			$display("FAIL bootstrap_max_abs_statistic");
		$finish;
	end

endmodule

>>> bootstrap_max_abs_statistic.f
src/bmas_pkg.sv
src/bmas_ram.sv
src/bmas_cell.sv
src/bmas_scale.sv
src/bootstrap_max_abs_statistic.sv
dv/tb_top.sv
